@@ hw/rtl/mefd_pkg.sv @@
// Shared types, constants and codes for the motor encoder feedback decoder.
package mefd_pkg;

    // Encoder counts per mechanical turn; must be a power of two.
    localparam int ENCODER_RANGE  = 8192;
    localparam int RANGE_LOG2     = $clog2(ENCODER_RANGE);
    // One full turn in Q8 degrees (360 * 256).
    localparam int Q8_FULL_TURN   = 92160;

    // Unwrapped encoder delta width: a 17-bit difference plus one range correction.
    localparam int DELTA_W        = 18;

    // Current scaling: large motor is x625/512, gimbal motor is x375/2048.
    localparam int LARGE_MUL      = 625;
    localparam int LARGE_SHIFT    = 9;
    localparam int GIMBAL_MUL     = 375;
    localparam int GIMBAL_SHIFT   = 11;
    localparam int CUR_MUL_W      = 10;
    localparam int CUR_PROD_W     = 27;

    // Register file.
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam logic [PADDR_W-1:0] REG_ADDR_MOTOR_KIND = 3'd0;

    // Motor kinds; the unused code behaves as the gimbal motor.
    localparam logic [1:0] KIND_SMALL  = 2'd0;
    localparam logic [1:0] KIND_LARGE  = 2'd1;
    localparam logic [1:0] KIND_GIMBAL = 2'd2;

    // Only frames of this length are decoded.
    localparam logic [3:0] FRAME_LEN_OK = 4'd8;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 152;

    typedef struct packed {
        logic [3:0]         frame_length;
        logic [7:0]         temperature_byte;
        logic signed [15:0] current_word;
        logic signed [15:0] speed_word;
        logic [15:0]        encoder_word;
    } t_frame;

    // Payload held between the tracker stage and the scaling stage.
    typedef struct packed {
        logic [15:0]        encoder_now;
        logic signed [15:0] speed_word;
        logic signed [15:0] current_word;
        logic [7:0]         temperature_byte;
        logic signed [31:0] multi_turn_count;
        logic               first_frame;
    } t_track;

    typedef struct packed {
        logic               first_frame;
        logic signed [35:0] total_angle_q8;
        logic signed [31:0] multi_turn_count;
        logic               temp_reported;
        logic [7:0]         temperature;
        logic signed [16:0] current_ma;
        logic signed [18:0] speed_dps;
        logic [19:0]        single_angle_q8;
        logic [15:0]        encoder_now;
    } t_result;

    // Handshake between two pipeline stages.
    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

@@ hw/rtl/mefd_apb_regs.sv @@
// APB register file holding the motor kind.
module mefd_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mefd_pkg::PADDR_W-1:0]   paddr,
    input  logic [mefd_pkg::PDATA_W-1:0]   pwdata,
    output logic [mefd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output logic [1:0]                     o_motor_kind
);
    import mefd_pkg::*;

    logic [1:0] r_motor_kind;
    logic       wr_kind;

    assign wr_kind = psel && penable && pwrite && (paddr == REG_ADDR_MOTOR_KIND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_kind <= KIND_SMALL;
        end else if (wr_kind) begin
            r_motor_kind <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_ADDR_MOTOR_KIND) begin
            prdata = {{(PDATA_W-2){1'b0}}, r_motor_kind};
        end
    end

    assign pready       = 1'b1;
    assign o_motor_kind = r_motor_kind;

endmodule

@@ hw/rtl/mefd_tracker.sv @@
// First stage: frame length filter, multi-turn unwrap and the tracker state.
module mefd_tracker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mefd_pkg::t_frame  i_frame,
    input  logic              i_next_ready,
    output mefd_pkg::t_hs     o_hs,
    output mefd_pkg::t_track  o_track
);
    import mefd_pkg::*;

    localparam logic signed [DELTA_W-1:0] HALF_RANGE = DELTA_W'(ENCODER_RANGE / 2);
    localparam logic signed [DELTA_W-1:0] FULL_RANGE = DELTA_W'(ENCODER_RANGE);

    logic                       r_valid;
    t_track                     r_track;
    logic [15:0]                r_last_encoder;
    logic signed [31:0]         r_turn_count;
    logic                       r_seeded;

    logic                       ready;
    logic                       take;
    logic signed [DELTA_W-1:0]  diff;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [31:0]         n_turn_count;

    assign ready = !r_valid || i_next_ready;
    assign take  = i_valid && ready && (i_frame.frame_length == FRAME_LEN_OK);

    // Shortest-way delta: anything beyond half a turn is taken the other way round.
    always_comb begin
        diff  = $signed({2'b00, i_frame.encoder_word}) - $signed({2'b00, r_last_encoder});
        delta = diff;
        if (diff > HALF_RANGE) begin
            delta = diff - FULL_RANGE;
        end else if (diff < -HALF_RANGE) begin
            delta = diff + FULL_RANGE;
        end
        if (r_seeded) begin
            n_turn_count = r_turn_count + {{(32-DELTA_W){delta[DELTA_W-1]}}, delta};
        end else begin
            n_turn_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_seeded       <= 1'b0;
            r_last_encoder <= '0;
            r_turn_count   <= '0;
        end else begin
            if (ready) begin
                r_valid <= take;
            end
            if (take) begin
                r_seeded       <= 1'b1;
                r_last_encoder <= i_frame.encoder_word;
                r_turn_count   <= n_turn_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_track.encoder_now      <= i_frame.encoder_word;
            r_track.speed_word       <= i_frame.speed_word;
            r_track.current_word     <= i_frame.current_word;
            r_track.temperature_byte <= i_frame.temperature_byte;
            r_track.multi_turn_count <= n_turn_count;
            r_track.first_frame      <= !r_seeded;
        end
    end

    assign o_hs.valid = r_valid;
    assign o_hs.ready = ready;
    assign o_track    = r_track;

endmodule

@@ hw/rtl/mefd_scaler.sv @@
// Second stage: unit scaling of the angle, speed and current fields into the result register.
module mefd_scaler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mefd_pkg::t_track  i_track,
    input  logic [1:0]        i_motor_kind,
    input  logic              i_m_ready,
    output mefd_pkg::t_hs     o_hs,
    output mefd_pkg::t_result o_result
);
    import mefd_pkg::*;

    localparam int ANG_W   = 33;
    localparam int TOTAL_W = 50;

    logic                          r_valid;
    t_result                       r_result;

    logic                          ready;
    logic                          load;
    logic [CUR_MUL_W-1:0]          cur_mul;
    logic signed [CUR_PROD_W-1:0]  cur_prod;
    logic signed [CUR_PROD_W-1:0]  cur_biased;
    logic signed [CUR_PROD_W-1:0]  cur_shifted;
    logic signed [18:0]            speed_ext;
    logic [ANG_W-1:0]              ang_prod;
    logic signed [TOTAL_W-1:0]     total_prod;
    logic signed [TOTAL_W-1:0]     total_biased;
    logic signed [TOTAL_W-1:0]     total_shifted;
    t_result                       n_result;

    assign ready = !r_valid || i_m_ready;
    assign load  = i_valid && ready;

    always_comb begin
        // Current: one shared multiplier, rounding toward zero by biasing negatives.
        cur_mul  = (i_motor_kind == KIND_LARGE) ? CUR_MUL_W'(LARGE_MUL)
                                                : CUR_MUL_W'(GIMBAL_MUL);
        cur_prod = $signed({{(CUR_PROD_W-16){i_track.current_word[15]}}, i_track.current_word})
                 * $signed({{(CUR_PROD_W-CUR_MUL_W){1'b0}}, cur_mul});
        if (i_motor_kind == KIND_LARGE) begin
            cur_biased  = cur_prod + (cur_prod[CUR_PROD_W-1] ?
                          CUR_PROD_W'((1 << LARGE_SHIFT) - 1) : '0);
            cur_shifted = cur_biased >>> LARGE_SHIFT;
        end else begin
            cur_biased  = cur_prod + (cur_prod[CUR_PROD_W-1] ?
                          CUR_PROD_W'((1 << GIMBAL_SHIFT) - 1) : '0);
            cur_shifted = cur_biased >>> GIMBAL_SHIFT;
        end

        speed_ext = {{3{i_track.speed_word[15]}}, i_track.speed_word};

        ang_prod = {{(ANG_W-16){1'b0}}, i_track.encoder_now} * ANG_W'(Q8_FULL_TURN);

        total_prod    = $signed({{(TOTAL_W-32){i_track.multi_turn_count[31]}},
                                 i_track.multi_turn_count}) * TOTAL_W'(Q8_FULL_TURN);
        total_biased  = total_prod + (total_prod[TOTAL_W-1] ?
                        TOTAL_W'(ENCODER_RANGE - 1) : '0);
        total_shifted = total_biased >>> RANGE_LOG2;

        n_result.encoder_now      = i_track.encoder_now;
        n_result.single_angle_q8  = 20'(ang_prod >> RANGE_LOG2);
        n_result.speed_dps        = (speed_ext <<< 2) + (speed_ext <<< 1);
        n_result.multi_turn_count = i_track.multi_turn_count;
        n_result.total_angle_q8   = total_shifted[35:0];
        n_result.first_frame      = i_track.first_frame;

        case (i_motor_kind)
            KIND_SMALL: begin
                n_result.current_ma    = {i_track.current_word[15], i_track.current_word};
                n_result.temperature   = '0;
                n_result.temp_reported = 1'b0;
            end
            default: begin
                n_result.current_ma    = cur_shifted[16:0];
                n_result.temperature   = i_track.temperature_byte;
                n_result.temp_reported = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= n_result;
        end
    end

    assign o_hs.valid = r_valid;
    assign o_hs.ready = ready;
    assign o_result   = r_result;

endmodule

@@ hw/rtl/motor_encoder_feedback_decoder_unit.sv @@
// Top level of the motor encoder feedback decoder with multi-turn unwrap.
//
// Usage: one feedback frame request enters on the s_axis channel, already split
// into the encoder, speed and current words, the temperature byte and the frame
// length. Frames whose length is not 8 are taken and dropped without a result.
// Every other frame gives one result request on the m_axis channel with the
// raw encoder, the single-turn and multi-turn angles in Q8 degrees, the speed
// in degrees per second, the scaled current in milliamps and the temperature.
// The motor kind register on the APB port selects the current scale and
// whether a temperature is reported; write it only while the block is idle.
//
// Each frame passes the tracker register, then the result register, before
// m_axis_tvalid. Throughput is one frame per cycle while m_axis_tready is high:
// the two stages form a pipeline, and a new frame is taken while the previous
// result waits. When m_axis_tready is low the result register holds its request,
// the tracker stage fills, then s_axis_tready drops until the result is taken.
// After reset the motor kind is the small current motor and the tracker is
// unseeded: the first good frame only loads the last encoder value and
// reports a zero multi-turn count and first_frame set.
module motor_encoder_feedback_decoder_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input frames.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // From bit 0 up: encoder_word[15:0], speed_word[31:16], current_word[47:32],
    // temperature_byte[55:48], frame_length[59:56], zero padding[63:60].
    input  logic [mefd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // Results.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // From bit 0 up: encoder_now[15:0], single_angle_q8[35:16], speed_dps[54:36],
    // current_ma[71:55], temperature[79:72], temp_reported[80],
    // multi_turn_count[112:81], total_angle_q8[148:113], first_frame[149],
    // zero padding[151:150].
    output logic [mefd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // Configuration.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mefd_pkg::PADDR_W-1:0]          paddr,
    input  logic [mefd_pkg::PDATA_W-1:0]          pwdata,
    output logic [mefd_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);
    import mefd_pkg::*;

    logic [1:0] motor_kind;
    t_frame     frame;
    t_track     track;
    t_result    result;
    t_hs        trk_hs;
    t_hs        scl_hs;

    // The frame struct lists its fields from the top bit down, so it packs
    // straight onto the low 60 bits of the stream data.
    assign frame = t_frame'(s_axis_tdata[$bits(t_frame)-1:0]);

    mefd_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_motor_kind (motor_kind)
    );

    // Stage one: length filter, unwrap and the running turn count.
    mefd_tracker u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_frame      (frame),
        .i_next_ready (scl_hs.ready),
        .o_hs         (trk_hs),
        .o_track      (track)
    );

    // Stage two: scaling into the result register that drives m_axis.
    mefd_scaler u_scaler (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (trk_hs.valid),
        .i_track      (track),
        .i_motor_kind (motor_kind),
        .i_m_ready    (m_axis_tready),
        .o_hs         (scl_hs),
        .o_result     (result)
    );

    assign s_axis_tready = trk_hs.ready;
    assign m_axis_tvalid = scl_hs.valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-$bits(t_result)){1'b0}}, result};

endmodule
